### hdl/pmec_pkg.sv
// Shared types and constants of the pseudo-median edge counter.
package pmec_pkg;

	localparam int SAMPLE_W = 10;
	localparam int THR_W    = 10;
	localparam int DEAD_W   = 16;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int QUOT_W   = 10;
	localparam int DIST_W   = 15;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Command codes of an input word.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Register byte addresses.
	localparam logic [APB_ADDR_W-1:0] ADDR_LEVEL_THRESHOLD = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_DEAD_WINDOW     = 3'd4;

	localparam logic [THR_W-1:0]   THR_RESET  = 10'd512;
	localparam logic [DEAD_W-1:0]  DEAD_RESET = 16'd1000;
	localparam logic [DIST_W-1:0]  DIST_INIT  = 15'd20000;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_ABSDIFF
	} alu_op_t;

endpackage

### hdl/pmec_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmec_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/pmec_alu.sv
// Shared add and absolute-difference unit of the sequencer.
module pmec_alu #(
	parameter int WIDTH = 14
) (
	input  pmec_pkg::alu_op_t  op,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	output logic [WIDTH-1:0]   res
);
	import pmec_pkg::*;

	logic [WIDTH:0] diff_ab;
	logic [WIDTH:0] diff_ba;

	always_comb begin
		diff_ab = {1'b0, a} - {1'b0, b};
		diff_ba = {1'b0, b} - {1'b0, a};
		res     = '0;
		unique case (op)
			ALU_ADD: begin
				res = a + b;
			end
			ALU_ABSDIFF: begin
				res = diff_ab[WIDTH] ? diff_ba[WIDTH-1:0] : diff_ab[WIDTH-1:0];
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

### hdl/pseudo_median_edge_counter_unit.sv
// Top level of the windowed pseudo-median threshold event counter.
// A word is taken only while idle: the window is summed, divided and scanned, and its result
// written out (a stalled output holds the done state) before the next. The shared unit sums
// the window and scans it again; the mean takes one reciprocal multiply. Reset: arst_n clears
// the window (valid bits per entry) and count at once, presets flag and config registers.
// No clearing pass is needed, so the block is ready in the first cycle after reset.
module pseudo_median_edge_counter_unit #(
	parameter int WINDOW_SIZE = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pmec_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pmec_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pmec_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// Input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [pmec_pkg::SAMPLE_W-1:0]       sample,
	input  logic [pmec_pkg::TIME_W-1:0]         now_ms,
	// Output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pmec_pkg::SAMPLE_W-1:0]       filtered_value,
	output logic                                object_present,
	output logic                                count_event,
	output logic [pmec_pkg::COUNT_W-1:0]        event_count
);
	import pmec_pkg::*;

	// The sum of the window never exceeds WINDOW_SIZE*1023, which sets the
	// width of the shared unit.
	localparam int SUM_W  = $clog2(WINDOW_SIZE * 1023 + 1);
	localparam int ADDR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
	// The rounded-up reciprocal with this shift gives the exact truncated
	// quotient for every sum that fits in SUM_W bits.
	localparam int REC_SH = SUM_W + $clog2(WINDOW_SIZE);
	localparam int REC_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + REC_W;
	localparam logic [REC_W-1:0]  REC_M    = REC_W'(((64'd1 << REC_SH) + 64'(WINDOW_SIZE)
	                                                 - 64'd1) / 64'(WINDOW_SIZE));
	localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WINDOW_SIZE);
	localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(WINDOW_SIZE - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                 state_q;

	// Configuration registers.
	logic [THR_W-1:0]       level_threshold_q;
	logic [DEAD_W-1:0]      dead_window_q;

	// Block state.
	logic [ADDR_W-1:0]      wr_idx_q;
	logic [WINDOW_SIZE-1:0] valid_q;
	logic                   present_q;
	logic [TIME_W-1:0]      last_detect_q;
	logic [COUNT_W-1:0]     counter_q;

	// Captured input word.
	logic                   cmd_q;
	logic [TIME_W-1:0]      now_q;

	// Sequencer working registers.
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       acc_q;
	logic [QUOT_W-1:0]      mean_q;
	logic [DIST_W-1:0]      best_dist_q;
	logic [SAMPLE_W-1:0]    best_val_q;
	logic                   rd_valid_q;

	// Output registers.
	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    filtered_q;
	logic                   present_out_q;
	logic                   fired_q;
	logic [COUNT_W-1:0]     count_out_q;

	// Window memory signals.
	logic                   accept_in;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [SAMPLE_W-1:0]    ram_rdata;
	logic [SAMPLE_W-1:0]    win_data;

	// Shared unit signals.
	alu_op_t                alu_op;
	logic [SUM_W-1:0]       alu_a;
	logic [SUM_W-1:0]       alu_b;
	logic [SUM_W-1:0]       alu_res;

	// Decision signals.
	logic                   cfg_write;
	logic [TIME_W-1:0]      elapsed;
	logic                   out_free;
	logic [PROD_W-1:0]      mean_prod;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_LEVEL_THRESHOLD) begin
			prdata = APB_DATA_W'(level_threshold_q);
		end else if (paddr == ADDR_DEAD_WINDOW) begin
			prdata = APB_DATA_W'(dead_window_q);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept_in = in_valid & in_ready;

	// A sample word writes its slot at the edge that accepts it, so the
	// summing pass that starts on the next cycle already sees it.
	assign ram_we    = accept_in & (cmd == CMD_SAMPLE);
	assign ram_raddr = (cnt_q < CNT_LAST) ? cnt_q[ADDR_W-1:0] : '0;

	pmec_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (sample),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// An entry that was never written since reset reads as zero.
	assign win_data = rd_valid_q ? ram_rdata : '0;

	// The sum pass adds, and the scan pass measures the distance of each
	// entry from the mean.
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = acc_q;
		alu_b  = SUM_W'(win_data);
		unique case (state_q)
			ST_SCAN: begin
				alu_op = ALU_ABSDIFF;
				alu_a  = SUM_W'(mean_q);
				alu_b  = SUM_W'(win_data);
			end
			ST_IDLE, ST_SUM, ST_DIV, ST_DONE: begin
				alu_op = ALU_ADD;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	pmec_alu #(
		.WIDTH (SUM_W)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res)
	);

	// Window sum times the reciprocal of the window size.
	assign mean_prod = PROD_W'(acc_q) * PROD_W'(REC_M);

	// Wrapping time since the last detection.
	assign elapsed  = now_q - last_detect_q;
	assign out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			level_threshold_q <= THR_RESET;
			dead_window_q     <= DEAD_RESET;
			wr_idx_q          <= '0;
			valid_q           <= '0;
			present_q         <= 1'b1;
			last_detect_q     <= '0;
			counter_q         <= '0;
			cnt_q             <= '0;
			rd_valid_q        <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (paddr == ADDR_LEVEL_THRESHOLD) begin
					level_threshold_q <= pwdata[THR_W-1:0];
				end else if (paddr == ADDR_DEAD_WINDOW) begin
					dead_window_q <= pwdata[DEAD_W-1:0];
				end
			end

			rd_valid_q <= valid_q[ram_raddr];

			// In the done state the new word replaces the one being taken.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						cmd_q <= cmd;
						now_q <= now_ms;
						cnt_q <= '0;
						acc_q <= '0;
						if (cmd == CMD_SAMPLE) begin
							valid_q[wr_idx_q] <= 1'b1;
							wr_idx_q <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
						end
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// Read data arrives in the cycle after its address is presented.
					if (cnt_q != '0) begin
						acc_q <= alu_res;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// Truncated mean from the product with the rounded-up reciprocal.
					mean_q      <= mean_prod[REC_SH +: QUOT_W];
					cnt_q       <= '0;
					best_dist_q <= DIST_INIT;
					best_val_q  <= '0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					// Strict compare keeps the lowest index on a tie.
					if (cnt_q != '0 && DIST_W'(alu_res[SAMPLE_W-1:0]) < best_dist_q) begin
						best_dist_q <= DIST_W'(alu_res[SAMPLE_W-1:0]);
						best_val_q  <= win_data;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						filtered_q  <= best_val_q;
						fired_q     <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (cmd_q == CMD_CLEAR) begin
							counter_q     <= '0;
							count_out_q   <= '0;
							present_out_q <= present_q;
						end else if (best_val_q > level_threshold_q) begin
							count_out_q   <= counter_q;
							present_out_q <= present_q;
							if (elapsed > TIME_W'(dead_window_q) && !present_q) begin
								if (counter_q != COUNT_MAX) begin
									counter_q   <= counter_q + 1'b1;
									count_out_q <= counter_q + 1'b1;
									fired_q     <= 1'b1;
								end
								last_detect_q <= now_q;
								present_q     <= 1'b1;
								present_out_q <= 1'b1;
							end
						end else begin
							present_q     <= 1'b0;
							present_out_q <= 1'b0;
							count_out_q   <= counter_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = filtered_q;
	assign object_present = present_out_q;
	assign count_event    = fired_q;
	assign event_count    = count_out_q;

endmodule
